// ----- rtl/blr_pkg.sv -----
// Package with shared constants for the Bresenham line rasteriser.
`timescale 1ns / 1ps
package blr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int QUEUE_DEPTH = 4;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_NEXT  = 1'b1;

endpackage

// ----- rtl/blr_in_if.sv -----
// Input channel interface carrying start and next-pixel commands.
`timescale 1ns / 1ps
interface blr_in_if #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

// ----- rtl/blr_out_if.sv -----
// Output channel interface carrying rasterised pixels.
`timescale 1ns / 1ps
interface blr_out_if #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ----- rtl/bresenham_line_rasterizer.sv -----
// Top level of the all-octant Bresenham line rasteriser.
// A next-pixel beat passes through the command queue and then the registered pixel output.
// Throughput: one beat per cycle while the output is not stalled; the stepper updates its error term on each pixel.
// A start beat gives no output and occupies one queue slot.
// Synchronous reset empties the command queue, drops the output and idles the stepper.
`timescale 1ns / 1ps
module bresenham_line_rasterizer #(
  parameter int COORD_BITS  = blr_pkg::COORD_BITS,
  parameter int QUEUE_DEPTH = blr_pkg::QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  blr_in_if.sink    in_ch,
  blr_out_if.source out_ch
);

  localparam int CMD_W = 4 * COORD_BITS + 5;

  logic             push;
  logic [CMD_W-1:0] push_cmd;
  logic             queue_ready;
  logic             pop;
  logic [CMD_W-1:0] head_cmd;
  logic             head_valid;

  blr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_ch       (in_ch),
    .push        (push),
    .cmd         (push_cmd),
    .queue_ready (queue_ready)
  );

  blr_queue #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_cmd),
    .push_ready (queue_ready),
    .pop        (pop),
    .pop_data   (head_cmd),
    .pop_valid  (head_valid)
  );

  blr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .cmd_valid (head_valid),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/blr_front.sv -----
// Front end: accepts input beats and classifies line setup into queue commands.
`timescale 1ns / 1ps
module blr_front #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS,
  localparam int CMD_W = 4 * COORD_BITS + 5
) (
  blr_in_if.sink     in_ch,
  output logic       push,
  output logic [CMD_W-1:0] cmd,
  input  logic       queue_ready
);

  localparam int N = COORD_BITS;

  typedef struct packed {
    logic                is_start;
    logic                steep;
    logic                neg;
    logic signed [N-1:0] x0;
    logic signed [N-1:0] y0;
    logic [N:0]          major;
    logic [N:0]          minor;
  } cmd_t;

  logic signed [N:0] dx;
  logic signed [N:0] dy;
  logic [N:0]        adx;
  logic [N:0]        ady;
  logic              steep;
  logic              swap;
  cmd_t              c;

  always_comb begin
    dx    = {in_ch.end_x[N-1], in_ch.end_x} - {in_ch.start_x[N-1], in_ch.start_x};
    dy    = {in_ch.end_y[N-1], in_ch.end_y} - {in_ch.start_y[N-1], in_ch.start_y};
    adx   = dx[N] ? $unsigned(-dx) : $unsigned(dx);
    ady   = dy[N] ? $unsigned(-dy) : $unsigned(dy);
    steep = adx < ady;
    if (!steep) begin
      swap = dy[N] || (dy == '0 && dx[N]);
    end else begin
      swap = dx[N] || (dx == '0 && dy[N]);
    end
    c.is_start = (in_ch.mode == blr_pkg::MODE_START);
    c.steep    = steep;
    c.neg      = (dx[N] && !dy[N] && dy != '0) || (dy[N] && !dx[N] && dx != '0);
    c.x0       = swap ? in_ch.end_x : in_ch.start_x;
    c.y0       = swap ? in_ch.end_y : in_ch.start_y;
    c.major    = steep ? ady : adx;
    c.minor    = steep ? adx : ady;
  end

  assign cmd         = c;
  assign push        = in_ch.valid && queue_ready;
  assign in_ch.ready = queue_ready;

endmodule

// ----- rtl/blr_queue.sv -----
// Short register queue decoupling the front end from the stepper.
`timescale 1ns / 1ps
module blr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = blr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> pop_valid)
    else $error("Queue popped while empty.");
  assert property (@(posedge clk) disable iff (rst) push |-> push_ready)
    else $error("Queue pushed while full.");
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("Queue count exceeds depth.");

endmodule

// ----- rtl/blr_back.sv -----
// Back end: line stepper with a registered pixel output.
`timescale 1ns / 1ps
module blr_back #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS,
  localparam int CMD_W = 4 * COORD_BITS + 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CMD_W-1:0] cmd,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  blr_out_if.source        out_ch
);

  localparam int N = COORD_BITS;
  localparam int E = COORD_BITS + 3;

  typedef struct packed {
    logic                is_start;
    logic                steep;
    logic                neg;
    logic signed [N-1:0] x0;
    logic signed [N-1:0] y0;
    logic [N:0]          major;
    logic [N:0]          minor;
  } cmd_t;

  cmd_t                c;
  logic signed [N-1:0] cur_x;
  logic signed [N-1:0] cur_y;
  logic signed [E-1:0] error_term;
  logic [N:0]          major_delta;
  logic [N:0]          minor_delta;
  logic                major_dir_negative;
  logic                steep;
  logic [N:0]          pixels_left;
  logic                active;
  logic                out_valid;

  logic                can_emit;
  logic                emit;
  logic signed [E-1:0] err_add;
  logic signed [E-1:0] err_sub;
  logic [N-1:0]        major_step;
  logic [N-1:0]        major_pos;
  logic [N-1:0]        minor_pos;
  logic                minor_move;

  assign c        = cmd;
  assign can_emit = !out_valid || out_ch.ready;
  assign emit     = cmd_valid && !c.is_start && active && can_emit;
  assign cmd_pop  = cmd_valid && (c.is_start || !active || can_emit);

  always_comb begin
    err_add    = error_term + $signed({1'b0, minor_delta, 1'b0});
    err_sub    = err_add - $signed({1'b0, major_delta, 1'b0});
    minor_move = !err_add[E-1];
    major_step = major_dir_negative ? '1 : N'(1);
    major_pos  = (steep ? cur_y : cur_x) + major_step;
    minor_pos  = (steep ? cur_x : cur_y) + N'(minor_move);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x              <= '0;
      cur_y              <= '0;
      error_term         <= '0;
      major_delta        <= '0;
      minor_delta        <= '0;
      major_dir_negative <= 1'b0;
      steep              <= 1'b0;
      pixels_left        <= '0;
      active             <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd_valid && c.is_start) begin
        cur_x              <= c.x0;
        cur_y              <= c.y0;
        major_delta        <= c.major;
        minor_delta        <= c.minor;
        error_term         <= -$signed({2'b00, c.major});
        major_dir_negative <= c.neg;
        steep              <= c.steep;
        pixels_left        <= c.major + 1'b1;
        active             <= 1'b1;
      end else if (emit) begin
        pixels_left <= pixels_left - 1'b1;
        if (pixels_left == (N + 1)'(1)) begin
          active <= 1'b0;
        end else begin
          error_term <= minor_move ? err_sub : err_add;
          if (steep) begin
            cur_y <= major_pos;
            cur_x <= minor_pos;
          end else begin
            cur_x <= major_pos;
            cur_y <= minor_pos;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.pixel_x    <= cur_x;
      out_ch.pixel_y    <= cur_y;
      out_ch.last_pixel <= (pixels_left == (N + 1)'(1));
    end
  end

  assign out_ch.valid = out_valid;

  assert property (@(posedge clk) disable iff (rst) active |-> pixels_left != '0)
    else $error("Active line with no pixels left.");
  assert property (@(posedge clk) disable iff (rst)
      emit && pixels_left == (N + 1)'(1) |=> !active && out_ch.last_pixel)
    else $error("Final pixel did not end the line.");
  assert property (@(posedge clk) disable iff (rst) emit |-> cmd_pop)
    else $error("Pixel emitted without consuming its command.");

endmodule

// ----- sim/blr_checker.sv -----
// Checker that predicts every pixel of the rasteriser and compares output beats against it.
`timescale 1ns / 1ps
module blr_checker (
  input  logic clk,
  input  logic rst,
  blr_in_if    in_ch,
  blr_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  localparam int CW = blr_pkg::COORD_BITS;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } pixel_t;

  pixel_t expected_pixels[$];

  logic [CW-1:0] pos_x;
  logic [CW-1:0] pos_y;
  int            err_acc;
  int            run_major;
  int            run_minor;
  bit            run_backward;
  bit            run_steep;
  int            pixels_remaining;
  bit            line_live;

  int fails = 0;
  int outstanding = 0;

  assign fail_count = fails;
  assign pending    = outstanding;

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic clear_line_state();
    pos_x            = '0;
    pos_y            = '0;
    err_acc          = 0;
    run_major        = 0;
    run_minor        = 0;
    run_backward     = 1'b0;
    run_steep        = 1'b0;
    pixels_remaining = 0;
    line_live        = 1'b0;
  endtask

  task automatic predict_beat();
    int     sx;
    int     sy;
    int     ex;
    int     ey;
    int     dx;
    int     dy;
    bit     swap;
    pixel_t px;
    if (in_ch.mode == blr_pkg::MODE_START) begin
      sx = int'(in_ch.start_x);
      sy = int'(in_ch.start_y);
      ex = int'(in_ch.end_x);
      ey = int'(in_ch.end_y);
      dx = ex - sx;
      dy = ey - sy;
      run_backward = (dx < 0 && dy > 0) || (dx > 0 && dy < 0);
      run_steep    = magnitude(dx) < magnitude(dy);
      if (!run_steep) begin
        swap = (dy < 0) || (dy == 0 && dx < 0);
      end else begin
        swap = (dx < 0) || (dx == 0 && dy < 0);
      end
      if (swap) begin
        sx = ex;
        sy = ey;
      end
      run_major        = run_steep ? magnitude(dy) : magnitude(dx);
      run_minor        = run_steep ? magnitude(dx) : magnitude(dy);
      err_acc          = -run_major;
      pos_x            = CW'(sx);
      pos_y            = CW'(sy);
      pixels_remaining = run_major + 1;
      line_live        = 1'b1;
    end else if (line_live) begin
      px.x    = pos_x;
      px.y    = pos_y;
      px.last = (pixels_remaining == 1);
      expected_pixels.push_back(px);
      pixels_remaining--;
      if (pixels_remaining == 0) begin
        line_live = 1'b0;
      end else begin
        if (run_steep) begin
          pos_y = run_backward ? pos_y - 1'b1 : pos_y + 1'b1;
        end else begin
          pos_x = run_backward ? pos_x - 1'b1 : pos_x + 1'b1;
        end
        err_acc += 2 * run_minor;
        if (err_acc >= 0) begin
          if (run_steep) begin
            pos_x = pos_x + 1'b1;
          end else begin
            pos_y = pos_y + 1'b1;
          end
          err_acc -= 2 * run_major;
        end
      end
    end
  endtask

  task automatic check_pixel();
    pixel_t px;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected pixel beat x=%0d y=%0d last=%0b", $time,
               out_ch.pixel_x, out_ch.pixel_y, out_ch.last_pixel);
      fails++;
    end else begin
      px = expected_pixels.pop_front();
      if (out_ch.pixel_x !== px.x) begin
        $display("%0t: pixel_x mismatch, expected %0d actual %0d", $time, px.x,
                 out_ch.pixel_x);
        fails++;
      end
      if (out_ch.pixel_y !== px.y) begin
        $display("%0t: pixel_y mismatch, expected %0d actual %0d", $time, px.y,
                 out_ch.pixel_y);
        fails++;
      end
      if (out_ch.last_pixel !== px.last) begin
        $display("%0t: last_pixel mismatch, expected %0b actual %0b", $time, px.last,
                 out_ch.last_pixel);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_line_state();
      expected_pixels.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_pixel();
      if (in_ch.valid && in_ch.ready) predict_beat();
    end
    outstanding <= expected_pixels.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top that drives line commands into the rasteriser and reports the verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int CW           = blr_pkg::COORD_BITS;
  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_ITEMS = 620;

  logic clk = 1'b0;
  logic rst;

  blr_in_if  in_if ();
  blr_out_if out_if ();

  int  fail_count;
  int  pending;
  int  sent = 0;
  int  idle_cycles = 0;
  int  ready_hold = 0;
  bit  calm = 1'b0;

  bresenham_line_rasterizer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  blr_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int line_length(int sx, int sy, int ex, int ey);
    int ax;
    int ay;
    ax = (ex > sx) ? ex - sx : sx - ex;
    ay = (ey > sy) ? ey - sy : sy - ey;
    return ((ax > ay) ? ax : ay) + 1;
  endfunction

  always @(posedge clk) begin
    if (calm) begin
      out_if.ready <= 1'b1;
      ready_hold   <= 0;
    end else if (ready_hold == 0) begin
      out_if.ready <= ($urandom_range(0, 2) != 0);
      ready_hold   <= pick_gap();
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_cmd(logic m, int sx, int sy, int ex, int ey);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= m;
    in_if.start_x <= CW'(sx);
    in_if.start_y <= CW'(sy);
    in_if.end_x   <= CW'(ex);
    in_if.end_y   <= CW'(ey);
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_next();
    send_cmd(blr_pkg::MODE_NEXT, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic draw_line(int sx, int sy, int ex, int ey, int beats);
    send_cmd(blr_pkg::MODE_START, sx, sy, ex, ey);
    repeat (beats) send_next();
  endtask

  task automatic wait_for_pixels();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int sx;
    int sy;
    int ex;
    int ey;
    int len;
    int beats;
    int r;
    rst           = 1'b1;
    in_if.valid   = 1'b0;
    in_if.mode    = blr_pkg::MODE_START;
    in_if.start_x = '0;
    in_if.start_y = '0;
    in_if.end_x   = '0;
    in_if.end_y   = '0;
    out_if.ready  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed lines: idle next, octants, flat backwards, single point, restarts, extremes.
    send_next();
    draw_line(0, 0, 3, 1, 4);
    draw_line(2, 5, 0, 0, 3);
    draw_line(5, -7, 2, -7, 5);
    draw_line(-3, 4, -3, 1, 2);
    draw_line(-2048, 2047, -2048, 2047, 2);
    draw_line(-2048, -2048, 2047, 2047, 2);
    draw_line(2047, -2048, -2048, 2047, 1);
    wait_for_pixels();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        send_cmd(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord());
      end else begin
        if ($urandom_range(0, 99) < 15) begin
          sx    = rand_coord();
          sy    = rand_coord();
          ex    = rand_coord();
          ey    = rand_coord();
          beats = $urandom_range(1, 40);
        end else begin
          sx  = int'($urandom_range(0, 4000)) - 2000;
          sy  = int'($urandom_range(0, 4000)) - 2000;
          ex  = sx + int'($urandom_range(0, 80)) - 40;
          ey  = sy + int'($urandom_range(0, 80)) - 40;
          len = line_length(sx, sy, ex, ey);
          r   = $urandom_range(0, 99);
          if (r < 70) beats = len;
          else if (r < 85) beats = $urandom_range(0, len - 1);
          else beats = len + $urandom_range(1, 3);
        end
        calm = ($urandom_range(0, 9) == 0);
        draw_line(sx, sy, ex, ey, beats);
        calm = 1'b0;
        if ($urandom_range(0, 24) == 0) wait_for_pixels();
      end
    end

    // A steep line from a corner of the coordinate range, walked to its end and one beat past.
    draw_line(2047, -2048, 1900, -1900, 150);

    wait_for_pixels();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/blr_pkg.sv
rtl/blr_in_if.sv
rtl/blr_out_if.sv
rtl/blr_front.sv
rtl/blr_queue.sv
rtl/blr_back.sv
rtl/bresenham_line_rasterizer.sv
sim/blr_checker.sv
sim/tb_top.sv
